>>> rtl/bilinear_texture_sampler_core_defines.svh
// Assertion macros used by the sampler back end.
`ifndef BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tbs_pkg.sv
// Shared types and constants of the texture sampler.
`timescale 1ns / 1ps
package tbs_pkg;
	localparam int ADDR_W = 24;
	localparam int WT_W   = 17;

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_HWRAP   = 3'd2;
	localparam logic [2:0] REG_VWRAP   = 3'd3;
	localparam logic [2:0] REG_NEAREST = 3'd4;

	localparam logic [WT_W-1:0] WT_ONE = 17'h10000;

	typedef enum logic [1:0] {
		WRAP_NONE    = 2'd0,
		WRAP_PAD     = 2'd1,
		WRAP_REPEAT  = 2'd2,
		WRAP_REFLECT = 2'd3
	} wrap_t;

	typedef struct packed {
		logic [8:0] width;
		logic [8:0] height;
		wrap_t      h_wrap;
		wrap_t      v_wrap;
		logic       nearest;
	} cfg_t;

	// One unit of work for the back end: a store write or a four-tap blend.
	typedef struct packed {
		logic                       is_load;
		logic [31:0]                texel;
		logic [3:0][ADDR_W-1:0]     addr;
		logic [3:0]                 mask;
		logic [3:0][WT_W-1:0]       wt;
	} entry_t;
endpackage

>>> rtl/tbs_front.sv
// Front end: accepts requests, wraps coordinates, computes weights and tap addresses.
`timescale 1ns / 1ps
module tbs_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [95:0]     in_data,
	input  logic            in_mode,
	input  tbs_pkg::cfg_t   cfg,
	output logic            q_valid,
	input  logic            q_ready,
	output tbs_pkg::entry_t q_entry
);
	import tbs_pkg::*;

	localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int NW   = $clog2(MAXD + 1);
	localparam int EW   = NW + 9;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIV  = 4'b0010,
		F_WGT  = 4'b0100,
		F_FIN  = 4'b1000
	} fstate_t;

	typedef struct packed {
		logic          ok;
		logic [NW-1:0] idx;
	} coord_t;

	fstate_t st_q;
	logic signed [15:0] lx_q, ly_q;
	logic [7:0] fx_q, fy_q;
	logic axis_q;
	logic [NW-1:0] rem_q;
	logic [15:0] dvd_q;
	logic [3:0] cnt_q;
	logic [NW-1:0] rx_q, ry_q;
	logic px_q, py_q;
	logic [1:0] wk_q;
	logic [3:0][WT_W-1:0] wt_q;
	entry_t ent_q;
	logic ent_v_q;

	function automatic logic [NW-1:0] eff_size(input logic [8:0] v, input logic [NW-1:0] mx);
		logic [EW-1:0] ve, me;
		ve = EW'(v);
		me = EW'(mx);
		if (v == 9'd0) return NW'(1);
		else if (ve > me) return mx;
		else return NW'(v);
	endfunction

	function automatic coord_t wrap_coord(input wrap_t md, input logic signed [16:0] x,
			input logic [NW-1:0] r, input logic p, input logic [NW-1:0] n);
		coord_t c;
		logic signed [16:0] ns;
		ns = signed'(17'(n));
		case (md)
			WRAP_PAD: begin
				c.ok = 1'b1;
				if (x < 0) c.idx = '0;
				else if (x >= ns) c.idx = n - NW'(1);
				else c.idx = NW'(x);
			end
			WRAP_REPEAT: begin
				c.ok = 1'b1;
				c.idx = r;
			end
			WRAP_REFLECT: begin
				c.ok = 1'b1;
				c.idx = p ? (n - NW'(1) - r) : r;
			end
			default: begin
				c.ok = (x >= 0) && (x < ns);
				c.idx = NW'(x);
			end
		endcase
		return c;
	endfunction

	logic [NW-1:0] w_eff, h_eff, n_cur;
	assign w_eff = eff_size(cfg.width, NW'(MAX_WIDTH));
	assign h_eff = eff_size(cfg.height, NW'(MAX_HEIGHT));
	assign n_cur = axis_q ? h_eff : w_eff;

	// one restoring step of |coord| / size
	logic [NW:0] div_t;
	logic div_ge;
	logic [NW-1:0] rem_nx;
	logic neg_cur;
	logic [NW-1:0] r_fin;
	logic p_fin;
	assign div_t  = {rem_q, dvd_q[15]};
	assign div_ge = div_t >= (NW+1)'(n_cur);
	assign rem_nx = div_ge ? NW'(div_t - (NW+1)'(n_cur)) : NW'(div_t);
	assign neg_cur = axis_q ? ly_q[15] : lx_q[15];
	always_comb begin
		if (neg_cur && rem_nx != '0) begin
			r_fin = n_cur - rem_nx;
			p_fin = !div_ge;
		end else begin
			r_fin = rem_nx;
			p_fin = div_ge;
		end
	end

	// integer parts of the sample coordinates
	logic signed [15:0] smp_x, smp_y;
	assign smp_x = signed'(in_data[71:56]);
	assign smp_y = signed'(in_data[95:80]);

	// tap formation
	logic signed [16:0] x0, x1, y0, y1;
	logic [NW-1:0] rx1, ry1;
	logic px1, py1;
	coord_t cx0, cx1, cy0, cy1;
	logic far_out;
	entry_t smp_ent;
	assign x0 = 17'(lx_q);
	assign x1 = x0 + 17'sd1;
	assign y0 = 17'(ly_q);
	assign y1 = y0 + 17'sd1;
	assign rx1 = (rx_q == w_eff - NW'(1)) ? '0 : rx_q + NW'(1);
	assign px1 = (rx_q == w_eff - NW'(1)) ? !px_q : px_q;
	assign ry1 = (ry_q == h_eff - NW'(1)) ? '0 : ry_q + NW'(1);
	assign py1 = (ry_q == h_eff - NW'(1)) ? !py_q : py_q;
	assign cx0 = wrap_coord(cfg.h_wrap, x0, rx_q, px_q, w_eff);
	assign cx1 = wrap_coord(cfg.h_wrap, x1, rx1, px1, w_eff);
	assign cy0 = wrap_coord(cfg.v_wrap, y0, ry_q, py_q, h_eff);
	assign cy1 = wrap_coord(cfg.v_wrap, y1, ry1, py1, h_eff);
	assign far_out = (cfg.h_wrap == WRAP_NONE) && (cfg.v_wrap == WRAP_NONE) &&
		((x0 < -17'sd1) || (x0 > signed'(17'(w_eff))) ||
		 (y0 < -17'sd1) || (y0 > signed'(17'(h_eff))));

	always_comb begin
		smp_ent = '0;
		smp_ent.addr[0] = ADDR_W'(cy0.idx) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx0.idx);
		smp_ent.addr[1] = ADDR_W'(cy0.idx) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx1.idx);
		smp_ent.addr[2] = ADDR_W'(cy1.idx) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx0.idx);
		smp_ent.addr[3] = ADDR_W'(cy1.idx) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx1.idx);
		if (far_out) begin
			smp_ent.mask = 4'b0000;
			smp_ent.wt = wt_q;
		end else if (cfg.nearest) begin
			smp_ent.mask = {3'b000, cx0.ok & cy0.ok};
			smp_ent.wt = {{3{WT_W'(0)}}, WT_ONE};
		end else begin
			smp_ent.mask = {cx1.ok & cy1.ok, cx0.ok & cy1.ok, cx1.ok & cy0.ok, cx0.ok & cy0.ok};
			smp_ent.wt = wt_q;
		end
	end

	// weight factors: tap k uses fx when k[0], fy when k[1]
	logic [8:0] wa, wb;
	logic [17:0] wprod;
	assign wa = wk_q[0] ? 9'(fx_q) : 9'd256 - 9'(fx_q);
	assign wb = wk_q[1] ? 9'(fy_q) : 9'd256 - 9'(fy_q);
	assign wprod = wa * wb;

	logic [7:0] ld_col, ld_row;
	logic ld_in_range;
	entry_t ld_ent;
	assign ld_col = in_data[7:0];
	assign ld_row = in_data[15:8];
	assign ld_in_range = (ADDR_W'(ld_col) < ADDR_W'(MAX_WIDTH)) &&
		(ADDR_W'(ld_row) < ADDR_W'(MAX_HEIGHT));

	always_comb begin
		ld_ent = '0;
		ld_ent.is_load = 1'b1;
		ld_ent.texel = in_data[47:16];
		ld_ent.addr[0] = ADDR_W'(ld_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ld_col);
	end

	assign in_ready = (st_q == F_IDLE) && !ent_v_q;
	assign q_valid  = ent_v_q;
	assign q_entry  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			ent_v_q <= 1'b0;
			axis_q <= 1'b0;
			cnt_q <= '0;
			wk_q <= '0;
		end else begin
			if (ent_v_q && q_ready) ent_v_q <= 1'b0;
			case (st_q)
				F_IDLE: begin
					if (in_valid && in_ready) begin
						if (!in_mode) begin
							ent_v_q <= ld_in_range;
						end else begin
							axis_q <= 1'b0;
							cnt_q <= '0;
							st_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
						end else begin
							wk_q <= '0;
							st_q <= F_WGT;
						end
					end
				end
				F_WGT: begin
					wk_q <= wk_q + 2'd1;
					if (wk_q == 2'd3) st_q <= F_FIN;
				end
				F_FIN: begin
					ent_v_q <= 1'b1;
					st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (in_valid && in_ready) begin
					if (!in_mode) begin
						ent_q <= ld_ent;
					end else begin
						lx_q <= smp_x;
						ly_q <= smp_y;
						fx_q <= in_data[55:48];
						fy_q <= in_data[79:72];
						rem_q <= '0;
						dvd_q <= smp_x[15] ? 16'(-smp_x) : smp_x;
					end
				end
			end
			F_DIV: begin
				if (cnt_q == 4'd15) begin
					rem_q <= '0;
					dvd_q <= ly_q[15] ? 16'(-ly_q) : ly_q;
					if (!axis_q) begin
						rx_q <= r_fin;
						px_q <= p_fin;
					end else begin
						ry_q <= r_fin;
						py_q <= p_fin;
					end
				end else begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[14:0], 1'b0};
				end
			end
			F_WGT: wt_q[wk_q] <= WT_W'(wprod);
			F_FIN: ent_q <= smp_ent;
			default: ;
		endcase
	end
endmodule

>>> rtl/tbs_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module tbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  tbs_pkg::entry_t wr_entry,
	output logic            rd_valid,
	input  logic            rd_ready,
	output tbs_pkg::entry_t rd_entry
);
	import tbs_pkg::*;

	entry_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_entry = slot_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_entry;
	end
endmodule

>>> rtl/tbs_back.sv
// Back end: image store, four-tap fetch and blend, output register.
`timescale 1ns / 1ps
module tbs_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  tbs_pkg::entry_t q_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_data
);
	import tbs_pkg::*;
	`include "bilinear_texture_sampler_core_defines.svh"

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_READ  = 3'b010,
		B_FLUSH = 3'b100
	} bstate_t;

	bstate_t st_q;
	entry_t e_q;
	logic [1:0] k_q;
	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_s1;
	logic rd_v_s1;
	logic [1:0] rd_k_s1;
	logic [3:0][23:0] acc_q;
	logic [3:0][23:0] sum;
	logic out_valid_q;
	logic [31:0] out_data_q;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [WT_W-1:0] wsel;
	logic [31:0] dsel;

	assign q_ready  = (st_q == B_IDLE) && (q_entry.is_load || !out_valid_q);
	assign mem_we   = (st_q == B_IDLE) && q_valid && q_entry.is_load;
	assign mem_addr = mem_we ? q_entry.addr[0][AW-1:0] : e_q.addr[k_q][AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= q_entry.texel;
		else rd_data_s1 <= mem[mem_addr];
	end

	// masked taps contribute nothing, whatever the store returned
	assign wsel = e_q.mask[rd_k_s1] ? e_q.wt[rd_k_s1] : '0;
	assign dsel = e_q.mask[rd_k_s1] ? rd_data_s1 : 32'h0;
	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			sum[ch] = ((rd_k_s1 == 2'd0) ? 24'd0 : acc_q[ch]) +
				24'(wsel * dsel[8*ch +: 8]);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			k_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (st_q == B_READ);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (q_valid && q_ready && !q_entry.is_load) begin
						k_q <= '0;
						st_q <= B_READ;
					end
				end
				B_READ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) st_q <= B_FLUSH;
				end
				B_FLUSH: begin
					out_valid_q <= 1'b1;
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= k_q;
		if (st_q == B_IDLE && q_valid && q_ready && !q_entry.is_load) e_q <= q_entry;
		if (rd_v_s1) acc_q <= sum;
		if (st_q == B_FLUSH)
			out_data_q <= {sum[3][23:16], sum[2][23:16], sum[1][23:16], sum[0][23:16]};
	end

	`TBS_ASSERT_IMP(a_no_start_busy, st_q == B_IDLE && q_valid && q_ready && !q_entry.is_load, !out_valid_q, "sample started while result pending")
	`TBS_ASSERT_IMP(a_flush_has_data, st_q == B_FLUSH, rd_v_s1 && rd_k_s1 == 2'd3, "last tap missing at flush")
	`TBS_ASSERT_IMP(a_rise_from_flush, $rose(out_valid_q), $past(st_q == B_FLUSH), "result raised outside flush")
	`TBS_ASSERT_NXT(a_write_idle, mem_we, st_q == B_IDLE, "store write left idle")
endmodule

>>> rtl/bilinear_texture_sampler_core.sv
// Top level of the bilinear texture sampler with per-axis wrap modes.
`timescale 1ns / 1ps
//  channel  | direction | handshake             | payload
//  s_axis   | in        | tvalid/tready         | tdata: col,row,texel,x,y; tuser: mode
//  m_axis   | out       | tvalid/tready         | tdata: red,green,blue,alpha
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  Load request: the front accepts it and hands it to the queue; the back end
//  writes it to the store.
//  Sample request: the front accepts it, runs a 16-step restoring division per axis
//  for the wrap remainder, four weight multiplies, tap formation and hand-off; the
//  back end does four single-port store reads and a flush; then the result is valid.
//  Front and back run apart through a two-entry queue; the result register
//  lets the front keep taking requests while a result waits.
//  Reset is asynchronous, active low; the image store is not cleared.
module bilinear_texture_sampler_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // load_col, load_row, load_texel, sample_x, sample_y
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // red, green, blue, alpha
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import tbs_pkg::*;

	cfg_t cfg_q;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	entry_t fq_entry, bq_entry;

	// registers are always writable; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= 9'd256;
			cfg_q.height  <= 9'd256;
			cfg_q.h_wrap  <= WRAP_NONE;
			cfg_q.v_wrap  <= WRAP_NONE;
			cfg_q.nearest <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:   cfg_q.width   <= cfg_data;
				REG_HEIGHT:  cfg_q.height  <= cfg_data;
				REG_HWRAP:   cfg_q.h_wrap  <= wrap_t'(cfg_data[1:0]);
				REG_VWRAP:   cfg_q.v_wrap  <= wrap_t'(cfg_data[1:0]);
				REG_NEAREST: cfg_q.nearest <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: classify, wrap, weigh
	tbs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_mode(s_axis_tuser),
		.cfg(cfg_q),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_entry(fq_entry)
	);

	tbs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_entry(fq_entry),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_entry(bq_entry)
	);

	// back: store access and blend
	tbs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_ready(bq_ready), .q_entry(bq_entry),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);
endmodule

>>> tb/bilinear_texture_sampler_core_checker.sv
// Result checker for the texture sampler: prediction and comparison.
`timescale 1ns / 1ps
module bilinear_texture_sampler_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	import tbs_pkg::*;

	logic [31:0] texels [0:65535];
	logic [8:0]  cfg_w, cfg_h;
	wrap_t       cfg_hw, cfg_vw;
	logic        cfg_near;
	logic [31:0] pixel_q [$];

	assign pending = pixel_q.size();

	function automatic int clip_size(logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return int'(v);
	endfunction

	function automatic int fmod(int x, int n);
		int r;
		r = x % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic int wrap_axis(wrap_t m, int x, int n);
		int r;
		case (m)
			WRAP_PAD: begin
				return x < 0 ? 0 : (x > n - 1 ? n - 1 : x);
			end
			WRAP_REPEAT: begin
				return fmod(x, n);
			end
			WRAP_REFLECT: begin
				r = fmod(x, n);
				return (((x - r) / n) & 1) ? n - 1 - r : r;
			end
			default: begin
				return x;
			end
		endcase
	endfunction

	function automatic logic [31:0] read_texel(int x, int y, int w, int h);
		int cx, cy;
		cx = wrap_axis(cfg_hw, x, w);
		cy = wrap_axis(cfg_vw, y, h);
		if (cx < 0 || cx >= w || cy < 0 || cy >= h)
			return 32'h0;
		return texels[cy * 256 + cx];
	endfunction

	function automatic logic [31:0] sample_pixel(logic [23:0] sx, logic [23:0] sy);
		int w, h, ix, iy;
		int unsigned fx, fy, acc;
		int unsigned wt [4];
		logic [31:0] px [4];
		logic [31:0] res;
		w = clip_size(cfg_w);
		h = clip_size(cfg_h);
		ix = int'($signed(sx[23:8]));
		iy = int'($signed(sy[23:8]));
		fx = sx[7:0];
		fy = sy[7:0];
		if (cfg_hw == WRAP_NONE && cfg_vw == WRAP_NONE
				&& (ix < -1 || ix > w || iy < -1 || iy > h))
			return 32'h0;
		if (cfg_near)
			return read_texel(ix, iy, w, h);
		wt[0] = (256 - fx) * (256 - fy);
		wt[1] = fx * (256 - fy);
		wt[2] = (256 - fx) * fy;
		wt[3] = fx * fy;
		px[0] = read_texel(ix, iy, w, h);
		px[1] = read_texel(ix + 1, iy, w, h);
		px[2] = read_texel(ix, iy + 1, w, h);
		px[3] = read_texel(ix + 1, iy + 1, w, h);
		for (int ch = 0; ch < 4; ch++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += wt[k] * px[k][8*ch +: 8];
			res[8*ch +: 8] = acc[23:16];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			cfg_w = 256;
			cfg_h = 256;
			cfg_hw = WRAP_NONE;
			cfg_vw = WRAP_NONE;
			cfg_near = 1'b0;
			fail_count = 0;
			pixel_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:   cfg_w = cfg_data;
					REG_HEIGHT:  cfg_h = cfg_data;
					REG_HWRAP:   cfg_hw = wrap_t'(cfg_data[1:0]);
					REG_VWRAP:   cfg_vw = wrap_t'(cfg_data[1:0]);
					REG_NEAREST: cfg_near = cfg_data[0];
					default: ;
				endcase
			end
			// result side first: a same-edge request cannot have produced it
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixel_q.size() == 0) begin
					$error("pixel with nothing expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = pixel_q.pop_front();
					if (m_axis_tdata[7:0] !== want[7:0]) begin
						$error("red: expected %h actual %h", want[7:0], m_axis_tdata[7:0]);
						fail_count++;
					end
					if (m_axis_tdata[15:8] !== want[15:8]) begin
						$error("green: expected %h actual %h", want[15:8],
							m_axis_tdata[15:8]);
						fail_count++;
					end
					if (m_axis_tdata[23:16] !== want[23:16]) begin
						$error("blue: expected %h actual %h", want[23:16],
							m_axis_tdata[23:16]);
						fail_count++;
					end
					if (m_axis_tdata[31:24] !== want[31:24]) begin
						$error("alpha: expected %h actual %h", want[31:24],
							m_axis_tdata[31:24]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (!s_axis_tuser)
					texels[{s_axis_tdata[15:8], s_axis_tdata[7:0]}] = s_axis_tdata[47:16];
				else
					pixel_q.push_back(sample_pixel(s_axis_tdata[71:48], s_axis_tdata[95:72]));
			end
		end
	end
endmodule

>>> tb/bilinear_texture_sampler_core_test.sv
// Top of the texture sampler testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module bilinear_texture_sampler_core_test;
	import tbs_pkg::*;

	localparam int TIMEOUT = 2000000;
	localparam int DRAIN   = 200;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          cycles;
	bit          hold_rx;     // long receiver hold-off request
	int          img_w, img_h;

	bilinear_texture_sampler_core i_dut (.*);

	bilinear_texture_sampler_core_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > TIMEOUT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, sometimes steady; a long hold-off on request.
	initial begin
		int hold;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
				hold_rx = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: m_axis_tready <= 1'b0;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	// Back-to-back writes keep valid high; the caller drops it after the last.
	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Quiesce before touching registers: stop sending, drain results, let loads settle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic setup(int w, int h, wrap_t hw, wrap_t vw, logic near);
		settle();
		write_reg(REG_WIDTH, 9'(w));
		write_reg(REG_HEIGHT, 9'(h));
		write_reg(REG_HWRAP, 9'(hw));
		write_reg(REG_VWRAP, 9'(vw));
		write_reg(REG_NEAREST, 9'(near));
		cfg_valid <= 1'b0;
		img_w = (w == 0) ? 1 : w;
		img_h = (h == 0) ? 1 : h;
	endtask

	// One request, sometimes with a random gap in front of it; bursts between gaps.
	task automatic send(logic mode, logic [95:0] payload);
		if ($urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tdata  <= payload;
		s_axis_tuser  <= mode;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic load_texel(int col, int row, logic [31:0] texel);
		send(1'b0, {48'h0, texel, 8'(row), 8'(col)});
	endtask

	task automatic sample_at(logic [23:0] sx, logic [23:0] sy);
		send(1'b1, {sy, sx, 48'h0});
	endtask

	// Fill the whole active image so that no fetch ever hits an unwritten texel.
	task automatic fill_image();
		for (int r = 0; r < img_h; r++)
			for (int c = 0; c < img_w; c++)
				load_texel(c, r, $urandom());
	endtask

	// Coordinate near the image, sometimes far out, sometimes fully random.
	function automatic logic [23:0] pick_coord(int n);
		case ($urandom_range(0, 5))
			0: return 24'($urandom());
			1: return 24'(($urandom_range(0, 8 * n) - 4 * n) * 256 + $urandom_range(0, 255));
			default: return 24'(($urandom_range(0, n + 3) - 2) * 256 + $urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int n_items;
		bit held;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_WIDTH;
		cfg_data      = '0;
		hold_rx       = 1'b0;
		held          = 1'b0;
		arst_n        = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: tiny image, every wrap mode, coordinate extremes.
		setup(2, 2, WRAP_NONE, WRAP_NONE, 1'b0);
		load_texel(0, 0, 32'hFFFF_FFFF);
		load_texel(1, 0, 32'h0000_0000);
		load_texel(0, 1, 32'h8040_2010);
		load_texel(1, 1, 32'h01FF_7F80);
		load_texel(255, 255, 32'hA5A5_5A5A);   // store corner, outside active image
		sample_at(24'h000000, 24'h000000);
		sample_at(24'h0000FF, 24'h0000FF);
		sample_at(24'hFFFF80, 24'hFFFF80);     // one texel left/up: edge blend with zero
		sample_at(24'h7FFFFF, 24'h000000);     // far out: both none gives zero
		sample_at(24'h800000, 24'h800000);
		sample_at(24'h000280, 24'h000180);     // just past right edge
		for (int m = 1; m < 4; m++) begin
			setup(2, 2, wrap_t'(m), wrap_t'(m), 1'b0);
			sample_at(24'h7FFFFF, 24'h800000);
			sample_at(24'hFFFD40, 24'h0005C0);
		end
		setup(2, 2, WRAP_NONE, WRAP_REPEAT, 1'b1);
		sample_at(24'h000180, 24'hFFFF00);
		sample_at(24'h000300, 24'h000100);
		// Size zero acts as one.
		setup(0, 0, WRAP_REFLECT, WRAP_PAD, 1'b0);
		sample_at(24'h123456, 24'hFEDCBA);

		// Sizes above the store saturate; clamping only ever reaches the corners.
		setup(300, 300, WRAP_PAD, WRAP_PAD, 1'b0);
		load_texel(0, 0, $urandom());
		load_texel(255, 0, $urandom());
		load_texel(0, 255, $urandom());
		load_texel(255, 255, $urandom());
		sample_at(24'h012B80, 24'h012B80);
		sample_at(24'hFFFB00, 24'hFFFB00);
		sample_at(24'h012B80, 24'hFFFD00);

		// Largest image: repeat and reflect across the far edges.
		setup(256, 256, WRAP_REPEAT, WRAP_REFLECT, 1'b0);
		load_texel(255, 255, $urandom());
		load_texel(0, 255, $urandom());
		sample_at(24'h00FF80, 24'h00FF40);

		// Random phases: small images, well-formed fill then samples.
		n_items = 0;
		while (n_items < 1500) begin
			setup($urandom_range(1, 12), $urandom_range(1, 12),
				wrap_t'($urandom_range(0, 3)), wrap_t'($urandom_range(0, 3)),
				$urandom_range(0, 1));
			fill_image();
			n_items += img_w * img_h;
			if (!held || $urandom_range(0, 3) == 0) begin
				hold_rx = 1'b1;   // receiver holds off while requests keep coming
				held = 1'b1;
			end
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(0, 9) == 0)
					load_texel($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1),
						$urandom());
				else
					sample_at(pick_coord(img_w), pick_coord(img_h));
				n_items++;
			end
		end

		settle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/tbs_pkg.sv
rtl/tbs_front.sv
rtl/tbs_queue.sv
rtl/tbs_back.sv
rtl/bilinear_texture_sampler_core.sv
tb/bilinear_texture_sampler_core_checker.sv
tb/bilinear_texture_sampler_core_test.sv
